// ===== design/v4alu_pkg.sv =====
// ----------------------------------------------------------------------------
// v4alu_pkg
// Shared types, opcodes and helpers for the four-lane Q16.16 vector ALU.
// ----------------------------------------------------------------------------
package v4alu_pkg;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_CROSS = 3'd4;
    localparam logic [2:0] OP_DOT   = 3'd5;
    localparam logic [2:0] OP_ROT   = 3'd6;

    // divider: 48 quotient bits, two per stage
    localparam int DIV_BITS   = 48;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEP;
    // stage that holds the non-divide result, and the output stage
    localparam int STG_RES    = 5;
    localparam int STG_OUT    = DIV_STAGES + 1;

    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    typedef struct packed {
        logic        ovf;
        logic [31:0] val;
    } t_sat;

    typedef struct packed {
        logic [31:0] rem;
        logic [47:0] dq;
    } t_dv;

    typedef struct packed {
        logic qneg;
        logic bz;
        logic an;
        logic az;
    } t_dmeta;

    function automatic t_sat sat32(input logic signed [65:0] v);
        t_sat s;
        if (v > SAT_HI) begin
            s.ovf = 1'b1;
            s.val = 32'h7FFF_FFFF;
        end else if (v < SAT_LO) begin
            s.ovf = 1'b1;
            s.val = 32'h8000_0000;
        end else begin
            s.ovf = 1'b0;
            s.val = v[31:0];
        end
        return s;
    endfunction

    // restoring division, quotient bits shift in where dividend bits leave
    function automatic t_dv div_step(input t_dv s, input logic [31:0] d);
        t_dv         t;
        logic [32:0] p;
        t = s;
        for (int k = 0; k < DIV_STEP; k++) begin
            p = {t.rem, t.dq[47]};
            if (p >= {1'b0, d}) begin
                p    = p - {1'b0, d};
                t.dq = {t.dq[46:0], 1'b1};
            end else begin
                t.dq = {t.dq[46:0], 1'b0};
            end
            t.rem = p[31:0];
        end
        return t;
    endfunction

endpackage

// ===== design/vec4_vector_alu.sv =====
// ----------------------------------------------------------------------------
// vec4_vector_alu
// Four-lane signed Q16.16 vector ALU: add, sub, mul, div, cross, dot, rotate.
// ----------------------------------------------------------------------------
// Input channel s_axis: tuser carries the opcode, tdata the vectors a and b.
// Output channel m_axis: tdata carries the four result lanes, tuser the
// saturated and divide-by-zero flags.
// The block is a 26-stage pipeline whatever the opcode, so items come out
// in order. Throughput is one item per cycle while the output is not
// stalled. The depth is set by the divider, which resolves two quotient bits
// per stage over 24 stages; the other ops finish by stage 5 and ride a delay
// line to the output.
// When m_axis_tready is low with a result waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits; the data registers
// are left as they are.
// ----------------------------------------------------------------------------
module vec4_vector_alu
    import v4alu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
    input  logic [2:0]   s_axis_tuser,  // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // r_x, r_y, r_z, r_w
    output logic [1:0]   m_axis_tuser   // saturated, divide_by_zero
);

    logic en;
    logic [STG_OUT:0] r_vld;
    logic [2:0] r_op [0:DIV_STAGES];

    logic signed [31:0] r_s0_a [4];
    logic signed [31:0] r_s0_b [4];

    // stage 1
    logic signed [63:0] r_s1_pm [4];
    logic signed [63:0] r_s1_px [6];
    logic signed [31:0] r_s1_a [4];
    logic signed [31:0] r_s1_b [4];

    // stage 2
    logic [31:0]        n_s2_res [4];
    logic               n_s2_sat;
    logic signed [31:0] n_s2_uv [3];
    logic               n_s2_uvsat;
    logic [31:0]        r_s2_res [4];
    logic               r_s2_sat;
    logic signed [31:0] r_s2_uv [3];
    logic               r_s2_uvsat;
    logic signed [31:0] r_s2_a [4];
    logic signed [31:0] r_s2_b [4];

    // stage 3
    logic signed [63:0] r_s3_q [6];
    logic signed [63:0] r_s3_m [3];
    logic [31:0]        r_s3_res [4];
    logic               r_s3_sat;
    logic               r_s3_uvsat;
    logic signed [31:0] r_s3_a [4];

    // stage 4
    logic signed [31:0] n_s4_uuv [3];
    logic               n_s4_rsat;
    logic signed [31:0] r_s4_uuv [3];
    logic signed [47:0] r_s4_m [3];
    logic               r_s4_rsat;
    logic [31:0]        r_s4_res [4];
    logic               r_s4_sat;
    logic signed [31:0] r_s4_a [4];

    // stage 5 and the delay line
    logic [31:0] n_s5_res [4];
    logic        n_s5_sat;
    logic [31:0] r_dl_res [STG_RES:DIV_STAGES][4];
    logic        r_dl_sat [STG_RES:DIV_STAGES];

    // divider
    t_dv         n_dv0 [4];
    logic [31:0] n_absb [4];
    t_dmeta      n_dm0 [4];
    t_dv         r_dv [DIV_STAGES][4];
    logic [31:0] r_dd [DIV_STAGES][4];
    t_dmeta      r_dm [DIV_STAGES][4];

    // output
    logic [127:0] n_out_data;
    logic [1:0]   n_out_user;
    logic [127:0] r_out_data;
    logic [1:0]   r_out_user;

    assign en            = !r_vld[STG_OUT] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[STG_OUT];
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[STG_OUT-1:0], s_axis_tvalid};
        end
    end

    // ---------------- stages 0 and 1: capture, products ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op[0] <= s_axis_tuser;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_op[k] <= r_op[k-1];
            end
            for (int i = 0; i < 4; i++) begin
                r_s0_a[i]  <= s_axis_tdata[32*i +: 32];
                r_s0_b[i]  <= s_axis_tdata[128+32*i +: 32];
                r_s1_pm[i] <= r_s0_a[i] * r_s0_b[i];
                r_s1_a[i]  <= r_s0_a[i];
                r_s1_b[i]  <= r_s0_b[i];
            end
            r_s1_px[0] <= r_s0_a[1] * r_s0_b[2];
            r_s1_px[1] <= r_s0_a[2] * r_s0_b[1];
            r_s1_px[2] <= r_s0_a[2] * r_s0_b[0];
            r_s1_px[3] <= r_s0_a[0] * r_s0_b[2];
            r_s1_px[4] <= r_s0_a[0] * r_s0_b[1];
            r_s1_px[5] <= r_s0_a[1] * r_s0_b[0];
        end
    end

    // ---------------- stage 2: lanewise ops, cross, dot, q x v ----------------
    always_comb begin
        logic signed [64:0] dc;
        logic signed [64:0] du;
        logic signed [65:0] dot;
        logic signed [32:0] s33;
        t_sat               st;
        n_s2_sat   = 1'b0;
        n_s2_uvsat = 1'b0;
        s33        = '0;
        for (int i = 0; i < 4; i++) begin
            n_s2_res[i] = '0;
        end
        for (int k = 0; k < 3; k++) begin
            dc = 65'(r_s1_px[2*k]) - 65'(r_s1_px[2*k+1]);
            du = 65'(r_s1_px[2*k+1]) - 65'(r_s1_px[2*k]);
            // floor of the exact difference
            st = sat32(66'($signed(du[64:16])));
            n_s2_uv[k] = st.val;
            n_s2_uvsat = n_s2_uvsat | st.ovf;
            if (r_op[1] == OP_CROSS) begin
                st = sat32(66'($signed(dc[64:16])));
                n_s2_res[k] = st.val;
                n_s2_sat    = n_s2_sat | st.ovf;
            end
        end
        dot = 66'(r_s1_pm[0]) + 66'(r_s1_pm[1]) + 66'(r_s1_pm[2]) + 66'(r_s1_pm[3]);
        case (r_op[1])
            OP_ADD, OP_SUB: begin
                for (int i = 0; i < 4; i++) begin
                    if (r_op[1] == OP_ADD) begin
                        s33 = 33'(r_s1_a[i]) + 33'(r_s1_b[i]);
                    end else begin
                        s33 = 33'(r_s1_a[i]) - 33'(r_s1_b[i]);
                    end
                    st = sat32(66'(s33));
                    n_s2_res[i] = st.val;
                    n_s2_sat    = n_s2_sat | st.ovf;
                end
            end
            OP_MUL: begin
                for (int i = 0; i < 4; i++) begin
                    st = sat32(66'($signed(r_s1_pm[i][63:16])));
                    n_s2_res[i] = st.val;
                    n_s2_sat    = n_s2_sat | st.ovf;
                end
            end
            OP_DOT: begin
                st = sat32(66'($signed(dot[65:16])));
                n_s2_res[0] = st.val;
                n_s2_sat    = st.ovf;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_sat   <= n_s2_sat;
            r_s2_uvsat <= n_s2_uvsat;
            for (int i = 0; i < 4; i++) begin
                r_s2_res[i] <= n_s2_res[i];
                r_s2_a[i]   <= r_s1_a[i];
                r_s2_b[i]   <= r_s1_b[i];
            end
            for (int k = 0; k < 3; k++) begin
                r_s2_uv[k] <= n_s2_uv[k];
            end
        end
    end

    // ---------------- stage 3: q x uv and w * uv products ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_q[0] <= r_s2_b[1] * r_s2_uv[2];
            r_s3_q[1] <= r_s2_b[2] * r_s2_uv[1];
            r_s3_q[2] <= r_s2_b[2] * r_s2_uv[0];
            r_s3_q[3] <= r_s2_b[0] * r_s2_uv[2];
            r_s3_q[4] <= r_s2_b[0] * r_s2_uv[1];
            r_s3_q[5] <= r_s2_b[1] * r_s2_uv[0];
            for (int k = 0; k < 3; k++) begin
                r_s3_m[k] <= r_s2_b[3] * r_s2_uv[k];
            end
            for (int i = 0; i < 4; i++) begin
                r_s3_res[i] <= r_s2_res[i];
                r_s3_a[i]   <= r_s2_a[i];
            end
            r_s3_sat   <= r_s2_sat;
            r_s3_uvsat <= r_s2_uvsat;
        end
    end

    // ---------------- stage 4: uuv ----------------
    always_comb begin
        logic signed [64:0] d;
        t_sat               st;
        n_s4_rsat = r_s3_uvsat;
        for (int k = 0; k < 3; k++) begin
            d  = 65'(r_s3_q[2*k]) - 65'(r_s3_q[2*k+1]);
            st = sat32(66'($signed(d[64:16])));
            n_s4_uuv[k] = st.val;
            n_s4_rsat   = n_s4_rsat | st.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_s4_uuv[k] <= n_s4_uuv[k];
                r_s4_m[k]   <= r_s3_m[k][63:16];
            end
            for (int i = 0; i < 4; i++) begin
                r_s4_res[i] <= r_s3_res[i];
                r_s4_a[i]   <= r_s3_a[i];
            end
            r_s4_rsat <= n_s4_rsat;
            r_s4_sat  <= r_s3_sat;
        end
    end

    // ---------------- stage 5: v + 2(w*uv + uuv) ----------------
    always_comb begin
        logic signed [65:0] t;
        t_sat               st;
        t  = '0;
        st = '0;
        if (r_op[4] == OP_ROT) begin
            n_s5_sat = r_s4_rsat;
            for (int k = 0; k < 3; k++) begin
                t  = 66'(r_s4_a[k]) + ((66'(r_s4_m[k]) + 66'(r_s4_uuv[k])) <<< 1);
                st = sat32(t);
                n_s5_res[k] = st.val;
                n_s5_sat    = n_s5_sat | st.ovf;
            end
            n_s5_res[3] = r_s4_a[3];
        end else begin
            n_s5_sat = r_s4_sat;
            for (int i = 0; i < 4; i++) begin
                n_s5_res[i] = r_s4_res[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl_sat[STG_RES] <= n_s5_sat;
            for (int i = 0; i < 4; i++) begin
                r_dl_res[STG_RES][i] <= n_s5_res[i];
            end
            for (int k = STG_RES + 1; k <= DIV_STAGES; k++) begin
                r_dl_sat[k] <= r_dl_sat[k-1];
                for (int i = 0; i < 4; i++) begin
                    r_dl_res[k][i] <= r_dl_res[k-1][i];
                end
            end
        end
    end

    // ---------------- divider, stages 1 to DIV_STAGES ----------------
    always_comb begin
        logic [31:0] au;
        logic [31:0] bu;
        for (int l = 0; l < 4; l++) begin
            au = r_s0_a[l];
            bu = r_s0_b[l];
            n_absb[l]     = bu[31] ? (~bu + 32'd1) : bu;
            n_dv0[l].rem  = '0;
            n_dv0[l].dq   = {(au[31] ? (~au + 32'd1) : au), 16'h0000};
            n_dm0[l].qneg = au[31] ^ bu[31];
            n_dm0[l].bz   = (bu == '0);
            n_dm0[l].an   = au[31];
            n_dm0[l].az   = (au == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 4; l++) begin
                r_dv[0][l] <= div_step(n_dv0[l], n_absb[l]);
                r_dd[0][l] <= n_absb[l];
                r_dm[0][l] <= n_dm0[l];
                for (int k = 1; k < DIV_STAGES; k++) begin
                    r_dv[k][l] <= div_step(r_dv[k-1][l], r_dd[k-1][l]);
                    r_dd[k][l] <= r_dd[k-1][l];
                    r_dm[k][l] <= r_dm[k-1][l];
                end
            end
        end
    end

    // ---------------- output stage ----------------
    always_comb begin
        logic [47:0] q;
        t_dmeta      m;
        logic [31:0] v;
        logic        sat;
        logic        dz;
        q          = '0;
        m          = '0;
        v          = '0;
        sat        = 1'b0;
        dz         = 1'b0;
        n_out_data = '0;
        if (r_op[DIV_STAGES] == OP_DIV) begin
            for (int l = 0; l < 4; l++) begin
                q = r_dv[DIV_STAGES-1][l].dq;
                m = r_dm[DIV_STAGES-1][l];
                if (m.bz) begin
                    dz = 1'b1;
                    if (m.an) begin
                        v = 32'h8000_0000;
                    end else if (m.az) begin
                        v = 32'h0000_0000;
                    end else begin
                        v = 32'h7FFF_FFFF;
                    end
                end else if (m.qneg) begin
                    if (q > 48'h0000_8000_0000) begin
                        v   = 32'h8000_0000;
                        sat = 1'b1;
                    end else begin
                        v = ~q[31:0] + 32'd1;
                    end
                end else begin
                    if (q > 48'h0000_7FFF_FFFF) begin
                        v   = 32'h7FFF_FFFF;
                        sat = 1'b1;
                    end else begin
                        v = q[31:0];
                    end
                end
                n_out_data[32*l +: 32] = v;
            end
        end else begin
            sat = r_dl_sat[DIV_STAGES];
            for (int l = 0; l < 4; l++) begin
                n_out_data[32*l +: 32] = r_dl_res[DIV_STAGES][l];
            end
        end
        n_out_user = {dz, sat};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

endmodule

// ===== design/v4alu_chk.sv =====
// ----------------------------------------------------------------------------
// v4alu_chk
// Port-level checks for the vector ALU, bound to the top level.
// ----------------------------------------------------------------------------
module v4alu_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    // held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // input side stalls exactly when a result waits on the output
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind vec4_vector_alu v4alu_chk u_v4alu_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Q16.16 vector ALU: a directed table of corner
// items, then random items, with random gaps and stalls on both streams.
// Every result is compared lane by lane against its typed table entry or a behavioral model.
// ----------------------------------------------------------------------------
module tb
    import v4alu_pkg::*;
();

    localparam int N_RANDOM   = 1700;
    localparam int WDOG_LIMIT = 2000;
    localparam int LATENCY    = 30;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] a[4];
        logic signed [31:0] b[4];
    } t_item;

    typedef struct {
        logic signed [31:0] r[4];
        logic               sat;
        logic               dz;
    } t_res;

    typedef struct {
        t_item it;
        bit    known;  // expected result typed in the table
        t_res  res;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
    logic [2:0]   s_axis_tuser;   // op
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;   // r_x, r_y, r_z, r_w
    logic [1:0]   m_axis_tuser;   // saturated, divide_by_zero

    t_res   result_q[$];
    int     n_fail = 0;
    int     idle_cycles = 0;
    t_row   rows[$];

    vec4_vector_alu dut (.*);

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // ---------------- behavioral model ----------------
    function automatic logic signed [31:0] clamp(input logic signed [127:0] v, inout logic f);
        if (v > 128'sd2147483647) begin
            f = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -128'sd2147483648) begin
            f = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // floor((p1 - p2) / 2^16); arithmetic shift floors
    function automatic logic signed [127:0] qdiff(input logic signed [127:0] p1,
                                                  input logic signed [127:0] p2);
        return (p1 - p2) >>> 16;
    endfunction

    function automatic void cross_prod(input logic signed [127:0] u[3],
                                       input logic signed [127:0] v[3],
                                       output logic signed [127:0] r[3], inout logic f);
        r[0] = 128'(clamp(qdiff(u[1] * v[2], v[1] * u[2]), f));
        r[1] = 128'(clamp(qdiff(u[2] * v[0], v[2] * u[0]), f));
        r[2] = 128'(clamp(qdiff(u[0] * v[1], v[0] * u[1]), f));
    endfunction

    function automatic t_res alu_predict(input t_item it);
        t_res                res;
        logic signed [127:0] a[4], b[4], acc, v3[3], q3[3], uv[3], uuv[3];
        logic                f;
        f = 1'b0;
        res.dz = 1'b0;
        for (int i = 0; i < 4; i++) begin
            a[i] = 128'(it.a[i]);
            b[i] = 128'(it.b[i]);
            res.r[i] = '0;
        end
        case (it.op)
            OP_ADD: for (int i = 0; i < 4; i++) res.r[i] = clamp(a[i] + b[i], f);
            OP_SUB: for (int i = 0; i < 4; i++) res.r[i] = clamp(a[i] - b[i], f);
            OP_MUL: for (int i = 0; i < 4; i++) res.r[i] = clamp((a[i] * b[i]) >>> 16, f);
            OP_DIV: for (int i = 0; i < 4; i++) begin
                if (b[i] == 0) begin
                    res.dz = 1'b1;
                    res.r[i] = a[i] > 0 ? 32'h7FFF_FFFF : (a[i] < 0 ? 32'h8000_0000 : 32'h0);
                end else begin
                    res.r[i] = clamp((a[i] * 65536) / b[i], f);  // truncates toward zero
                end
            end
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    v3[i] = a[i];
                    q3[i] = b[i];
                end
                cross_prod(v3, q3, uv, f);
                for (int i = 0; i < 3; i++) res.r[i] = uv[i][31:0];
            end
            OP_DOT: begin
                acc = 0;
                for (int i = 0; i < 4; i++) acc += a[i] * b[i];
                res.r[0] = clamp(acc >>> 16, f);
            end
            OP_ROT: begin
                for (int i = 0; i < 3; i++) begin
                    v3[i] = a[i];
                    q3[i] = b[i];
                end
                cross_prod(q3, v3, uv, f);
                cross_prod(q3, uv, uuv, f);
                for (int i = 0; i < 3; i++)
                    res.r[i] = clamp(a[i] + 2 * (((b[3] * uv[i]) >>> 16) + uuv[i]), f);
                res.r[3] = it.a[3];
            end
            default: ;
        endcase
        res.sat = f;
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic logic [31:0] rand_lane(input bit unit);
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom;
            4: return $signed($urandom_range(0, 8)) <<< 16;  // small integers
            default: return unit ? $signed($urandom_range(0, 131072)) - 65536
                                 : $signed($urandom_range(0, 1 << 24)) - (1 << 23);
        endcase
    endfunction

    function automatic t_item rand_item();
        t_item it;
        bit    unit;
        it.op = 3'($urandom_range(0, 7));
        unit = $urandom_range(0, 3) != 0;
        for (int i = 0; i < 4; i++) begin
            it.a[i] = rand_lane(1'b0);
            it.b[i] = (it.op == OP_DIV && $urandom_range(0, 7) == 0) ? 32'h0
                                                                    : rand_lane(unit);
        end
        return it;
    endfunction

    function automatic t_item mk(input logic [2:0] op, input logic [31:0] av,
                                 input logic [31:0] bv);
        t_item it;
        it.op = op;
        for (int i = 0; i < 4; i++) begin
            it.a[i] = av;
            it.b[i] = bv;
        end
        return it;
    endfunction

    function automatic void add_row(input t_item it, input bit known,
                                    input logic [31:0] rv, input logic s, input logic d);
        t_row row;
        row.it = it;
        row.known = known;
        for (int i = 0; i < 4; i++) row.res.r[i] = rv;
        row.res.sat = s;
        row.res.dz = d;
        rows.push_back(row);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input t_item it, input t_res exp_res);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {it.b[3], it.b[2], it.b[1], it.b[0],
                          it.a[3], it.a[2], it.a[1], it.a[0]};
        do @(posedge i_clk); while (!s_axis_tready);
        result_q.push_back(exp_res);
        @(negedge i_clk);
    endtask

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_res e;
            if (result_q.size() == 0) begin
                $error("result with no item outstanding: %h", m_axis_tdata);
                n_fail++;
            end else begin
                e = result_q.pop_front();
                for (int i = 0; i < 4; i++)
                    if (m_axis_tdata[32*i +: 32] !== e.r[i]) begin
                        $error("r_%s expected %h actual %h", (i == 0) ? "x" : (i == 1) ? "y"
                               : (i == 2) ? "z" : "w", e.r[i], m_axis_tdata[32*i +: 32]);
                        n_fail++;
                    end
                if (m_axis_tuser[0] !== e.sat) begin
                    $error("saturated expected %b actual %b", e.sat, m_axis_tuser[0]);
                    n_fail++;
                end
                if (m_axis_tuser[1] !== e.dz) begin
                    $error("divide_by_zero expected %b actual %b", e.dz, m_axis_tuser[1]);
                    n_fail++;
                end
            end
        end
    end

    // receiver stalls: a random wait per result, with stretches of ready held high
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(10, 60)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
                while (!m_axis_tvalid) @(posedge i_clk);
            end
        end
    end

    // watchdog on cycles with nothing accepted
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("FAIL vec4_vector_alu");
            $finish;
        end
    end

    initial begin
        t_res exp_res;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;

        add_row(mk(OP_ADD, 32'h7FFF_FFFF, 32'h1), 1, 32'h7FFF_FFFF, 1, 0);
        add_row(mk(OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF), 1, 32'h8000_0000, 1, 0);
        add_row(mk(OP_ADD, 32'h0001_0000, 32'h0002_0000), 1, 32'h0003_0000, 0, 0);
        add_row(mk(OP_SUB, 32'h8000_0000, 32'h1), 1, 32'h8000_0000, 1, 0);
        add_row(mk(OP_SUB, 32'h7FFF_FFFF, 32'h8000_0000), 1, 32'h7FFF_FFFF, 1, 0);
        add_row(mk(OP_MUL, 32'h0002_0000, 32'h0003_0000), 1, 32'h0006_0000, 0, 0);
        add_row(mk(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1, 32'h7FFF_FFFF, 1, 0);
        add_row(mk(OP_MUL, 32'h8000_0000, 32'h8000_0000), 1, 32'h7FFF_FFFF, 1, 0);
        add_row(mk(OP_MUL, 32'hFFFF_FFFF, 32'h1), 0, 0, 0, 0);
        add_row(mk(OP_DIV, 32'h0006_0000, 32'h0002_0000), 1, 32'h0003_0000, 0, 0);
        add_row(mk(OP_DIV, 32'h0001_0000, 32'h0), 1, 32'h7FFF_FFFF, 0, 1);
        add_row(mk(OP_DIV, 32'hFFFF_0000, 32'h0), 1, 32'h8000_0000, 0, 1);
        add_row(mk(OP_DIV, 32'h0, 32'h0), 1, 32'h0, 0, 1);
        add_row(mk(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF), 1, 32'h7FFF_FFFF, 1, 0);
        add_row(mk(OP_DIV, 32'hFFFF_FFFF, 32'h0003_0000), 0, 0, 0, 0);
        add_row(mk(OP_CROSS, 32'h7FFF_FFFF, 32'h8000_0000), 0, 0, 0, 0);
        add_row(mk(OP_DOT, 32'h0001_0000, 32'h0002_0000), 0, 0, 0, 0);
        add_row(mk(OP_DOT, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, 0, 0, 0);
        add_row(mk(OP_DOT, 32'hFFFF_FFFF, 32'h1), 0, 0, 0, 0);
        add_row(mk(OP_ROT, 32'h0001_0000, 32'h0), 0, 0, 0, 0);
        add_row(mk(OP_ROT, 32'h8000_0000, 32'h7FFF_FFFF), 0, 0, 0, 0);
        add_row(mk(3'd7, 32'h1234_5678, 32'h0), 1, 32'h0, 0, 0);
        rows[15].it.a[1] = 32'h0001_0000;  // cross with mixed lanes
        rows[19].it.b[3] = 32'h0001_0000;  // rotate by identity quaternion
        rows[20].it.b[0] = 32'h0000_B505;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[k]) begin
            exp_res = alu_predict(rows[k].it);
            if (rows[k].known) begin
                exp_res.r[3] = rows[k].res.r[3];
                exp_res = rows[k].res;
            end
            send_item(rows[k].it, exp_res);
        end

        // hold off until the pipeline drains completely
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(negedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            t_item it;
            it = rand_item();
            send_item(it, alu_predict(it));
        end
        s_axis_tvalid <= 1'b0;

        while (result_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
        if (n_fail == 0 && result_q.size() == 0)
            $display("PASS vec4_vector_alu");
        else
            $display("FAIL vec4_vector_alu");
        $finish;
    end
endmodule

// ===== vec4_vector_alu.f =====
design/v4alu_pkg.sv
design/vec4_vector_alu.sv
design/v4alu_chk.sv
tb/tb.sv
